### rtl/core/cerf_pkg.sv
`default_nettype none
package cerf_pkg;

  localparam int TERM_W    = 32;
  localparam int ID_W      = 4;
  localparam int TALLY_W   = 4;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;

  // largest cluster size (other nodes) honored by the majority check
  localparam logic [CFG_W-1:0] MAX_PEERS = 4'd8;

  localparam logic [TERM_W-1:0]  TERM_TOP  = '1;
  localparam logic [TALLY_W-1:0] TALLY_TOP = '1;

  // event codes on the input stream
  localparam logic [2:0] FUNC_ELECT_TO = 3'd0;
  localparam logic [2:0] FUNC_VOTE_REP = 3'd1;
  localparam logic [2:0] FUNC_HB_REP   = 3'd2;
  localparam logic [2:0] FUNC_APP_REP  = 3'd3;
  localparam logic [2:0] FUNC_HB_TO    = 3'd4;
  localparam logic [2:0] FUNC_APP_REQ  = 3'd5;
  localparam logic [2:0] FUNC_VOTE_REQ = 3'd6;

  // roles
  localparam logic [1:0] ROLE_FOLLOWER  = 2'd0;
  localparam logic [1:0] ROLE_CANDIDATE = 2'd1;
  localparam logic [1:0] ROLE_LEADER    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PEER_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID     = 1'b1;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // decoded event as handed from front to back
  typedef struct packed {
    logic                elect_to;
    logic                vote_rep;
    logic                hb_rep;
    logic                app_rep;
    logic                hb_to;
    logic                app_req;
    logic                vote_req;
    logic [TERM_W-1:0]   msg_term;
    logic [TERM_W-1:0]   sent_term;
    logic                failed;
    logic                grant;
    logic [ID_W-1:0]     cand;
    logic                msg_gt_sent;
    logic                msg_eq_sent;
  } cerf_cmd_t;

  // result item, role in the lowest bits
  typedef struct packed {
    logic                arm_hb;
    logic                restart_timer;
    logic                send_beats;
    logic                start_elect;
    logic                reply_ok;
    logic [TERM_W-1:0]   reply_term;
    logic [TERM_W-1:0]   current_term;
    logic [1:0]          role;
  } cerf_res_t;

endpackage
`default_nettype wire

### rtl/core/cerf_front.sv
`default_nettype none
module cerf_front
  import cerf_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [71:0]     s_tdata,   // msg_term, sent_term, rpc_failed, granted, cand_id
  input  wire logic [2:0]      s_tuser,   // func
  output logic                 cmd_valid,
  input  wire logic            cmd_ready,
  output cerf_cmd_t            cmd
);

  logic      held;
  cerf_cmd_t held_cmd;
  cerf_cmd_t dec;
  logic      take;

  always_comb begin
    dec           = '0;
    dec.msg_term  = s_tdata[31:0];
    dec.sent_term = s_tdata[63:32];
    dec.failed    = s_tdata[64];
    dec.grant     = s_tdata[65];
    dec.cand      = s_tdata[69:66];
    dec.msg_gt_sent = dec.msg_term > dec.sent_term;
    dec.msg_eq_sent = dec.msg_term == dec.sent_term;
    case (s_tuser)
      FUNC_ELECT_TO: dec.elect_to = 1'b1;
      FUNC_VOTE_REP: dec.vote_rep = 1'b1;
      FUNC_HB_REP:   dec.hb_rep   = 1'b1;
      FUNC_APP_REP:  dec.app_rep  = 1'b1;
      FUNC_HB_TO:    dec.hb_to    = 1'b1;
      FUNC_APP_REQ:  dec.app_req  = 1'b1;
      FUNC_VOTE_REQ: dec.vote_req = 1'b1;
      default: ;  // unknown code: all flags low, back gives a no-op result
    endcase
  end

  assign s_tready  = !held || cmd_ready;
  assign take      = s_tvalid && s_tready;
  assign cmd_valid = held;
  assign cmd       = held_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (cmd_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_cmd <= dec;
    end
  end

endmodule
`default_nettype wire

### rtl/core/cerf_queue.sv
`default_nettype none
module cerf_queue
  import cerf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire cerf_cmd_t push_cmd,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output cerf_cmd_t      pop_cmd
);

  cerf_cmd_t        mem [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr;
  logic [Q_AW-1:0]  rd_ptr;
  logic [Q_CW-1:0]  count;
  logic             push;
  logic             pop;

  assign push_ready = count != Q_CW'(Q_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CW'(Q_DEPTH))
    else $error("queue count above depth");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");
`endif

endmodule
`default_nettype wire

### rtl/core/cerf_back.sv
`default_nettype none
module cerf_back
  import cerf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 cmd_valid,
  output logic                      cmd_ready,
  input  wire cerf_cmd_t            cmd,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output cerf_res_t                 res
);

  // configuration
  logic [CFG_W-1:0]   peer_count;
  logic [ID_W-1:0]    own_id;

  // node state
  logic [1:0]         node_role, node_role_next;
  logic [TERM_W-1:0]  term_reg, term_reg_next;
  logic               vote_cast, vote_cast_next;
  logic [ID_W-1:0]    voted_id, voted_id_next;
  logic [TALLY_W-1:0] vote_tally, vote_tally_next;

  cerf_res_t          res_next;
  logic               fire;
  logic [CFG_W-1:0]   peers;
  logic [CFG_W-1:0]   majority;
  logic               msg_gt_term;
  logic               msg_lt_term;
  logic               step_down;
  logic [TALLY_W-1:0] tally_inc;
  logic               vr_role_f;
  logic               vr_cast;

  assign cmd_ready = !res_valid || res_ready;
  assign fire      = cmd_valid && cmd_ready;

  assign peers    = (peer_count > MAX_PEERS) ? MAX_PEERS : peer_count;
  assign majority = CFG_W'((peers + 1'b1) >> 1);

  assign msg_gt_term = cmd.msg_term > term_reg;
  assign msg_lt_term = cmd.msg_term < term_reg;
  assign tally_inc   = (vote_tally < TALLY_TOP) ? vote_tally + 1'b1 : vote_tally;

  // vote request: role and vote mark after a possible step-down
  assign vr_role_f = msg_gt_term || (node_role == ROLE_FOLLOWER);
  assign vr_cast   = !msg_gt_term && vote_cast;

  always_comb begin
    node_role_next  = node_role;
    term_reg_next   = term_reg;
    vote_cast_next  = vote_cast;
    voted_id_next   = voted_id;
    vote_tally_next = vote_tally;
    step_down       = 1'b0;
    res_next        = '0;

    if (cmd.elect_to) begin
      if (node_role != ROLE_LEADER && cmd.sent_term == term_reg) begin
        term_reg_next         = (term_reg == TERM_TOP) ? term_reg : term_reg + 1'b1;
        node_role_next        = ROLE_CANDIDATE;
        vote_cast_next        = 1'b1;
        voted_id_next         = own_id;
        vote_tally_next       = TALLY_W'(1);
        res_next.start_elect  = 1'b1;
        res_next.restart_timer = 1'b1;
      end
    end else if (cmd.vote_rep) begin
      if (!cmd.failed) begin
        if (cmd.msg_gt_sent) begin
          step_down = 1'b1;
        end else if (cmd.msg_eq_sent && cmd.grant) begin
          vote_tally_next = tally_inc;
          if (tally_inc > majority) begin
            node_role_next  = ROLE_LEADER;
            res_next.arm_hb = 1'b1;
          end
        end
      end
    end else if (cmd.hb_rep) begin
      step_down = !cmd.failed && !cmd.grant && cmd.msg_gt_sent;
    end else if (cmd.app_rep) begin
      step_down = !cmd.failed && msg_gt_term;
    end else if (cmd.hb_to) begin
      if (node_role == ROLE_LEADER) begin
        res_next.send_beats = 1'b1;
        res_next.arm_hb     = 1'b1;
      end
    end else if (cmd.app_req) begin
      res_next.reply_term = term_reg;
      if (!msg_lt_term) begin
        term_reg_next          = cmd.msg_term;
        res_next.restart_timer = 1'b1;
        res_next.reply_ok      = 1'b1;
        step_down              = node_role != ROLE_FOLLOWER;
      end
    end else if (cmd.vote_req) begin
      step_down           = msg_gt_term;
      res_next.reply_term = msg_gt_term ? cmd.msg_term : term_reg;
      if (!msg_lt_term && vr_role_f && !vr_cast) begin
        vote_cast_next         = 1'b1;
        voted_id_next          = cmd.cand;
        res_next.restart_timer = 1'b1;
        res_next.reply_ok      = 1'b1;
      end
    end

    // step-down to the message term; a vote granted in the same request wins
    if (step_down) begin
      term_reg_next          = cmd.msg_term;
      node_role_next         = ROLE_FOLLOWER;
      res_next.restart_timer = 1'b1;
      if (!res_next.reply_ok || cmd.app_req) begin
        vote_cast_next = 1'b0;
        voted_id_next  = '0;
      end
    end

    res_next.role         = node_role_next;
    res_next.current_term = term_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peer_count <= CFG_W'(2);
      own_id     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PEER_COUNT: peer_count <= cfg_data;
        CFG_OWN_ID:     own_id     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_role  <= ROLE_FOLLOWER;
      term_reg   <= '0;
      vote_cast  <= 1'b0;
      voted_id   <= '0;
      vote_tally <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (fire) begin
        node_role  <= node_role_next;
        term_reg   <= term_reg_next;
        vote_cast  <= vote_cast_next;
        voted_id   <= voted_id_next;
        vote_tally <= vote_tally_next;
        res_valid  <= 1'b1;
      end else if (res_ready) begin
        res_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_start_is_cand: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.start_elect |-> res.restart_timer && res.role == ROLE_CANDIDATE)
    else $error("election start without candidate role and timer pulse");

  a_granted_vote_marked: assert property (@(posedge clk) disable iff (rst)
    fire && cmd.vote_req && res_next.reply_ok |=> vote_cast && node_role == ROLE_FOLLOWER)
    else $error("vote granted but not recorded");
`endif

endmodule
`default_nettype wire

### rtl/core/consensus_election_role_fsm.sv
`default_nettype none
// Election role machine of one cluster node. Each request on the s_ side is one
// event (timer expiry, reply to an RPC this node sent, or an incoming append or
// vote request) and yields exactly one result request on the m_ side carrying
// the role and term after the event, the answer for incoming requests, and
// action pulses (start election, send heartbeats, restart election timer, arm
// heartbeat timer). The block takes one event per clock unless the result side
// stalls. Each event is held in the decode register of the front end, then in
// the two-entry queue; then the back end updates the node state and registers
// the result. The back end's registered state update is the loop that sets the
// rate. Configuration (peer_count, own_id) is written on the cfg_ port; the user
// must do so only while no event is in flight; the block does not enforce it.
module consensus_election_role_fsm
  import cerf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration write
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // event stream
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [71:0]          s_tdata,   // msg_term, sent_term, rpc_failed, granted, cand_id
  input  wire logic [2:0]           s_tuser,   // func
  // result stream
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [71:0]               m_tdata    // role, current_term, reply_term, reply_ok,
                                               // start_election, send_heartbeats,
                                               // restart_election_timer, arm_heartbeat_timer
);

  // front -> queue
  logic      f_valid;
  logic      f_ready;
  cerf_cmd_t f_cmd;

  // queue -> back
  logic      q_valid;
  logic      q_ready;
  cerf_cmd_t q_cmd;

  cerf_res_t res;

  // front: take events and decode the event code and term compares
  cerf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  // short queue so a stalled result side does not stop event intake at once
  cerf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  // back: node state, role rules, registered result
  cerf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  // pad to whole bytes
  assign m_tdata = {1'b0, res};

endmodule
`default_nettype wire

### verif/consensus_election_role_fsm_tb.sv
`timescale 1ns / 100ps

// Testbench for the election role machine. Events go in on the s_ stream, one
// result per event comes back on the m_ stream. A local copy of the node state
// (role, term, vote mark, tally) predicts each result as its event is taken;
// the result process compares every field in arrival order.
module consensus_election_role_fsm_tb;
  import cerf_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [71:0]          s_tdata = '0;  // msg_term, sent_term, rpc_failed, granted, cand_id
  logic [2:0]           s_tuser = '0;  // func
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [71:0]          m_tdata;       // role, current_term, reply_term, reply_ok,
                                       // start_election, send_heartbeats,
                                       // restart_election_timer, arm_heartbeat_timer

  consensus_election_role_fsm u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Node state as the testbench sees it
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]   peer_cfg = 4'd2;
  logic [ID_W-1:0]    own_cfg  = '0;
  logic [1:0]         node_role = ROLE_FOLLOWER;
  logic [TERM_W-1:0]  node_term = '0;
  logic               vote_cast = 1'b0;
  logic [ID_W-1:0]    voted_for = '0;
  logic [TALLY_W-1:0] vote_tally = '0;

  cerf_res_t expected_results[$];
  int        events_sent = 0;
  int        mismatches = 0;
  bit        no_gaps = 1'b0;   // set for a phase with both sides at full rate
  int        ready_hold = 0;

  // gap length in cycles: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void step_down_to(input logic [TERM_W-1:0] t);
    node_term = t;
    node_role = ROLE_FOLLOWER;
    vote_cast = 1'b0;
    voted_for = '0;
  endfunction

  // Advances the local node state by one event and returns the result it owes.
  function automatic cerf_res_t predict_event(input logic [2:0] fn,
                                              input logic [TERM_W-1:0] mt, st,
                                              input logic fl, gr,
                                              input logic [ID_W-1:0] cd);
    cerf_res_t        r;
    logic             timer;
    logic [CFG_W-1:0] peers;
    r = '0;
    timer = 1'b0;
    peers = (peer_cfg > MAX_PEERS) ? MAX_PEERS : peer_cfg;
    case (fn)
      FUNC_ELECT_TO: begin
        // stale timers and leaders ignore the timeout
        if (node_role != ROLE_LEADER && st == node_term) begin
          if (node_term != TERM_TOP) node_term = node_term + 1'b1;
          node_role = ROLE_CANDIDATE;
          vote_cast = 1'b1;
          voted_for = own_cfg;
          vote_tally = TALLY_W'(1);
          r.start_elect = 1'b1;
          timer = 1'b1;
        end
      end
      FUNC_VOTE_REP: begin
        if (!fl) begin
          if (mt > st) begin
            step_down_to(mt);
            timer = 1'b1;
          end else if (mt == st && gr) begin
            // tally counts regardless of role or current term
            if (vote_tally != TALLY_TOP) vote_tally = vote_tally + 1'b1;
            if (int'(vote_tally) > (int'(peers) + 1) / 2) begin
              node_role = ROLE_LEADER;
              r.arm_hb = 1'b1;
            end
          end
        end
      end
      FUNC_HB_REP: begin
        if (!fl && !gr && mt > st) begin
          step_down_to(mt);
          timer = 1'b1;
        end
      end
      FUNC_APP_REP: begin
        if (!fl && mt > node_term) begin
          step_down_to(mt);
          timer = 1'b1;
        end
      end
      FUNC_HB_TO: begin
        if (node_role == ROLE_LEADER) begin
          r.send_beats = 1'b1;
          r.arm_hb = 1'b1;
        end
      end
      FUNC_APP_REQ: begin
        r.reply_term = node_term;
        if (mt >= node_term) begin
          node_term = mt;
          timer = 1'b1;
          // a follower keeps its vote mark
          if (node_role != ROLE_FOLLOWER) step_down_to(mt);
          r.reply_ok = 1'b1;
        end
      end
      FUNC_VOTE_REQ: begin
        if (mt > node_term) begin
          step_down_to(mt);
          timer = 1'b1;
        end
        r.reply_term = node_term;
        // one vote per term, and only a follower grants it
        if (!(mt < node_term || node_role != ROLE_FOLLOWER || vote_cast)) begin
          vote_cast = 1'b1;
          voted_for = cd;
          timer = 1'b1;
          r.reply_ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.role = node_role;
    r.current_term = node_term;
    r.restart_timer = timer;
    return r;
  endfunction

  // term close to the current one, so that events mostly land
  function automatic logic [TERM_W-1:0] near_term();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return node_term;
      6, 7: return node_term + 1;
      8: return node_term - $urandom_range(1, 3);
      default: return node_term + $urandom_range(2, 5);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Event driver: one request, predicted at the edge it is taken
  // ---------------------------------------------------------------------------
  task automatic send_event(input logic [2:0] fn, input logic [TERM_W-1:0] mt, st,
                            input logic fl, gr, input logic [ID_W-1:0] cd);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {2'b00, cd, gr, fl, st, mt};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_results = {expected_results, predict_event(fn, mt, st, fl, gr, cd)};
    events_sent++;
  endtask

  // stop sending and wait out every pending result
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // only called with nothing in flight
  task automatic set_config(input logic [CFG_W-1:0] peers, input logic [ID_W-1:0] id);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PEER_COUNT;
    cfg_data  <= peers;
    @(posedge clk);
    cfg_index <= CFG_OWN_ID;
    cfg_data  <= id;
    @(posedge clk);
    cfg_we <= 1'b0;
    peer_cfg = peers;
    own_cfg  = id;
    @(posedge clk);
  endtask

  // Random traffic: mostly coherent episodes (elections with vote bursts,
  // leader heartbeats, follower requests, step-downs), the rest noise.
  task automatic run_random_events(input int count);
    int                stop_at;
    int                k;
    logic [TERM_W-1:0] t;
    logic [2:0]        fn;
    stop_at = events_sent + count;
    while (events_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          send_event(FUNC_ELECT_TO, $urandom,
                     ($urandom_range(0, 9) == 0) ? near_term() : node_term,
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     ID_W'($urandom_range(0, 15)));
          t = node_term;
          k = $urandom_range(0, 16);
          repeat (k)
            send_event(FUNC_VOTE_REP,
                       ($urandom_range(0, 11) == 0) ? t + $urandom_range(1, 3) : t, t,
                       $urandom_range(0, 7) == 0, $urandom_range(0, 3) != 0,
                       ID_W'($urandom_range(0, 15)));
          if (node_role == ROLE_LEADER) begin
            repeat ($urandom_range(1, 4)) begin
              send_event(FUNC_HB_TO, $urandom, $urandom, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), ID_W'($urandom_range(0, 15)));
              send_event(FUNC_HB_REP, t, t, $urandom_range(0, 7) == 0,
                         $urandom_range(0, 3) != 0, ID_W'($urandom_range(0, 15)));
            end
          end
        end
        3, 4: begin
          send_event(FUNC_HB_TO, $urandom, $urandom, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), ID_W'($urandom_range(0, 15)));
          send_event(FUNC_HB_REP, near_term(), node_term, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), ID_W'($urandom_range(0, 15)));
          send_event(FUNC_APP_REP, near_term(), node_term, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), ID_W'($urandom_range(0, 15)));
        end
        5, 6: begin
          send_event(FUNC_APP_REQ, near_term(), $urandom, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), ID_W'($urandom_range(0, 15)));
          t = near_term();
          repeat ($urandom_range(1, 3))
            send_event(FUNC_VOTE_REQ, t, $urandom, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), ID_W'($urandom_range(0, 15)));
        end
        7: begin
          // higher term seen in a reply or request
          case ($urandom_range(0, 3))
            0: fn = FUNC_VOTE_REP;
            1: fn = FUNC_HB_REP;
            2: fn = FUNC_APP_REP;
            default: fn = FUNC_VOTE_REQ;
          endcase
          send_event(fn, node_term + $urandom_range(1, 2), node_term, 1'b0, 1'b0,
                     ID_W'($urandom_range(0, 15)));
        end
        default: begin
          send_event(3'($urandom_range(0, 6)),
                     ($urandom_range(0, 15) == 0) ? $urandom : near_term(),
                     ($urandom_range(0, 3) == 0) ? $urandom : near_term(),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     ID_W'($urandom_range(0, 15)));
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // One pass over every event kind and the role transitions, small terms.
  task automatic test_basic_events();
    set_config(4'd2, 4'd15);
    send_event(FUNC_HB_TO,    32'd0, 32'd0, 1'b0, 1'b0, 4'd0);      // follower: no beats
    send_event(FUNC_ELECT_TO, 32'd0, 32'd5, 1'b0, 1'b0, 4'd0);      // stale timer
    send_event(FUNC_ELECT_TO, 32'd0, 32'd0, 1'b0, 1'b0, 4'd0);      // candidate, term 1
    send_event(FUNC_VOTE_REP, 32'd1, 32'd1, 1'b1, 1'b1, 4'd0);      // transport failure
    send_event(FUNC_VOTE_REP, 32'd1, 32'd1, 1'b0, 1'b0, 4'd0);      // vote refused
    send_event(FUNC_VOTE_REP, 32'd3, 32'd5, 1'b0, 1'b1, 4'd0);      // older term than sent
    send_event(FUNC_VOTE_REP, 32'd1, 32'd1, 1'b0, 1'b1, 4'd0);      // majority: leader
    send_event(FUNC_ELECT_TO, 32'd0, 32'd1, 1'b0, 1'b0, 4'd0);      // leader ignores timeout
    send_event(FUNC_HB_TO,    32'd0, 32'd0, 1'b0, 1'b0, 4'd0);      // beats + arm
    send_event(FUNC_HB_REP,   32'd1, 32'd1, 1'b0, 1'b1, 4'd0);
    send_event(FUNC_APP_REP,  32'd1, 32'd1, 1'b0, 1'b1, 4'd0);
    send_event(FUNC_VOTE_REQ, 32'd1, 32'd0, 1'b0, 1'b0, 4'd3);      // leader refuses vote
    send_event(FUNC_HB_REP,   32'd4, 32'd1, 1'b0, 1'b0, 4'd0);      // step down to 4
    send_event(FUNC_APP_REQ,  32'd2, 32'd0, 1'b0, 1'b0, 4'd0);      // lower term refused
    send_event(FUNC_APP_REQ,  32'd4, 32'd0, 1'b0, 1'b0, 4'd0);      // accepted
    send_event(FUNC_VOTE_REQ, 32'd4, 32'd0, 1'b0, 1'b0, 4'd15);     // vote granted
    send_event(FUNC_VOTE_REQ, 32'd4, 32'd0, 1'b0, 1'b0, 4'd15);     // repeat refused
    send_event(FUNC_VOTE_REQ, 32'd6, 32'hFFFF_FFFF, 1'b1, 1'b1, 4'd0); // newer term: grant
    send_event(FUNC_ELECT_TO, 32'd0, 32'd6, 1'b0, 1'b0, 4'd0);      // candidate, term 7
    send_event(FUNC_APP_REQ,  32'd7, 32'd0, 1'b0, 1'b0, 4'd0);      // candidate steps down
    send_event(FUNC_ELECT_TO, 32'd0, 32'd7, 1'b0, 1'b0, 4'd0);      // candidate, term 8
    send_event(FUNC_APP_REP,  32'd9, 32'd8, 1'b0, 1'b0, 4'd0);      // step down to 9
    send_event(FUNC_ELECT_TO, 32'd0, 32'd9, 1'b0, 1'b0, 4'd0);      // candidate, term 10
    send_event(FUNC_VOTE_REP, 32'd12, 32'd10, 1'b0, 1'b1, 4'd0);    // step down to 12
    send_event(FUNC_HB_REP,   32'd20, 32'd0, 1'b1, 1'b0, 4'd0);     // failure ignored
    send_event(FUNC_VOTE_REQ, 32'd0, 32'd0, 1'b0, 1'b0, 4'd0);      // lower term refused
  endtask

  // Random traffic under several cluster sizes and ids, extremes included.
  // Each phase starts from an idle block, so the sender waits for every
  // outstanding result before the configuration changes.
  task automatic test_random_sweep();
    logic [CFG_W-1:0] peer_list[6];
    logic [ID_W-1:0]  id_list[6];
    peer_list = '{4'd0, 4'd8, 4'd1, 4'd5, 4'd3, 4'd8};
    id_list   = '{4'd15, 4'd7, 4'd3, 4'd10, 4'd0, 4'd15};
    for (int i = 0; i < 6; i++) begin
      drain_results();
      set_config(peer_list[i], id_list[i]);
      no_gaps = (i == 2);
      run_random_events(240);
    end
    no_gaps = 1'b0;
  endtask

  // Term stuck at its top value, tally saturating, then traffic at the top.
  task automatic test_term_saturation();
    drain_results();
    set_config(4'd8, 4'd9);
    send_event(FUNC_APP_REQ,  32'hFFFF_FFFE, 32'd0, 1'b0, 1'b0, 4'd0);
    send_event(FUNC_ELECT_TO, 32'd0, 32'hFFFF_FFFE, 1'b0, 1'b0, 4'd0);
    send_event(FUNC_ELECT_TO, 32'd0, TERM_TOP, 1'b0, 1'b0, 4'd0);   // no wrap
    repeat (17) send_event(FUNC_VOTE_REP, TERM_TOP, TERM_TOP, 1'b0, 1'b1, 4'd0);
    send_event(FUNC_HB_TO,    32'd0, 32'd0, 1'b0, 1'b0, 4'd0);
    send_event(FUNC_VOTE_REQ, TERM_TOP, 32'd0, 1'b0, 1'b0, 4'd15);
    send_event(FUNC_APP_REQ,  TERM_TOP, 32'd0, 1'b0, 1'b0, 4'd0);
    send_event(FUNC_VOTE_REQ, TERM_TOP, 32'd0, 1'b0, 1'b0, 4'd15);
    run_random_events(150);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, field-by-field compare against oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void compare_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    cerf_res_t got;
    cerf_res_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = cerf_res_t'(m_tdata[70:0]);
        if (expected_results.size() == 0) begin
          $error("result with no pending event: %h", m_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          compare_field("role", 32'(want.role), 32'(got.role));
          compare_field("current_term", want.current_term, got.current_term);
          compare_field("reply_term", want.reply_term, got.reply_term);
          compare_field("reply_ok", 32'(want.reply_ok), 32'(got.reply_ok));
          compare_field("start_election", 32'(want.start_elect), 32'(got.start_elect));
          compare_field("send_heartbeats", 32'(want.send_beats), 32'(got.send_beats));
          compare_field("restart_election_timer", 32'(want.restart_timer),
                        32'(got.restart_timer));
          compare_field("arm_heartbeat_timer", 32'(want.arm_hb), 32'(got.arm_hb));
        end
      end
      if (ready_hold > 0) begin
        m_tready <= 1'b0;
        ready_hold--;
      end else begin
        m_tready <= 1'b1;
        ready_hold = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_events();
    test_random_sweep();
    test_term_saturation();
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("consensus_election_role_fsm_tb passed");
    end else begin
      $display("consensus_election_role_fsm_tb failed");
    end
    $finish;
  end

  // hang guard, well above the slowest legal run
  initial begin
    #2000000;
    $display("consensus_election_role_fsm_tb failed");
    $finish;
  end

endmodule
